### hw/rtl/hfb_pkg.sv
// Shared codes, widths and control types of the Huffman tree builder.
package hfb_pkg;

	localparam int ID_W = 9;
	localparam logic [ID_W-1:0] FIRST_INTERNAL = 9'd256;

	// request codes carried in s_tuser
	localparam logic [1:0] REQ_COUNT = 2'd0;
	localparam logic [1:0] REQ_MERGE = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// result status codes
	localparam logic [2:0] ST_COUNTED = 3'd0;
	localparam logic [2:0] ST_MERGED  = 3'd1;
	localparam logic [2:0] ST_SINGLE  = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_DONE    = 3'd4;

	// build phases
	localparam logic [1:0] PH_COUNT = 2'd0;
	localparam logic [1:0] PH_MERGE = 2'd1;
	localparam logic [1:0] PH_DONE  = 2'd2;

	// control of the two-minimum tracker
	typedef struct packed {
		logic init;
		logic take;
	} min2_ctl_t;

endpackage

### hw/rtl/hfb_min2.sv
// Tracker of the two least keys seen during one heap scan.
module hfb_min2 import hfb_pkg::*; #(
	parameter int KW = 41,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  min2_ctl_t     ctl,
	input  logic [KW-1:0] key,
	input  logic [SW-1:0] idx,
	output logic [KW-1:0] min1_key,
	output logic [SW-1:0] min1_idx,
	output logic [KW-1:0] min2_key,
	output logic [SW-1:0] min2_idx
);

	logic have1_q, have2_q;
	logic [KW-1:0] k1_q, k2_q;
	logic [SW-1:0] i1_q, i2_q;

	// track presence of the two slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have1_q <= 1'b0;
			have2_q <= 1'b0;
		end else if (ctl.init) begin
			have1_q <= 1'b0;
			have2_q <= 1'b0;
		end else if (ctl.take) begin
			have1_q <= 1'b1;
			if (!have1_q || key < k1_q) begin
				have2_q <= have1_q;
			end else begin
				have2_q <= 1'b1;
			end
		end
	end

	// insert the incoming key into the sorted pair
	always_ff @(posedge clk) begin
		if (ctl.take && !ctl.init) begin
			if (!have1_q || key < k1_q) begin
				k2_q <= k1_q;
				i2_q <= i1_q;
				k1_q <= key;
				i1_q <= idx;
			end else if (!have2_q || key < k2_q) begin
				k2_q <= key;
				i2_q <= idx;
			end
		end
	end

	assign min1_key = k1_q;
	assign min1_idx = i1_q;
	assign min2_key = k2_q;
	assign min2_idx = i2_q;

endmodule

### hw/rtl/huffman_tree_builder_top.sv
// Top level of the Huffman tree builder: histogram, node store and sequencer.
//
// Input stream: s_tuser carries the request (count, merge, clear), s_tdata the
// symbol. Output stream: one result transaction per count or merge request,
// m_tuser the status, m_tlast set on the result that completes the tree;
// clear gives none. One request is in work at a time; s_tready is high while
// the sequencer is idle, even while a finished result still waits on m_tready.
// Steps from the accepting edge until the result is offered on m_tvalid:
//   count: histogram read and increment write, then result load; only the
//     result load once building has started.
//   merge: one pass over the node store finds the two least (frequency, id)
//     nodes, one read per cycle, and the new node is written into a freed
//     slot; a move and a put follow when both freed slots need a refill.
//   first merge: first one histogram entry read per cycle to load the node
//     store. Merge after completion: result load only.
// Reset and clear empty the histogram at once through per-entry valid bits;
// the node store needs no clearing. A stalled receiver holds the result in
// the output register; the next request then waits at its result load.
module huffman_tree_builder_top import hfb_pkg::*; #(
	parameter int SYMBOLS    = 256,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] symbol
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [8:0] left_node, [17:9] right_node,
	                               // [26:18] new_node, [58:27] merged_freq
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast    // tree_done
);

	localparam int SW = $clog2(SYMBOLS);
	localparam int CW = $clog2(SYMBOLS + 1);
	localparam int KW = COUNT_BITS + ID_W;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_HWR  = 4'd1;
	localparam logic [3:0] S_LOAD = 4'd2;
	localparam logic [3:0] S_MBEG = 4'd3;
	localparam logic [3:0] S_SGL  = 4'd4;
	localparam logic [3:0] S_SCAN = 4'd5;
	localparam logic [3:0] S_FIX  = 4'd6;
	localparam logic [3:0] S_MOV  = 4'd7;
	localparam logic [3:0] S_PUT  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [3:0] state_q;
	logic [1:0] phase_q;
	logic [CW-1:0] cnt_q, k_q;
	logic [ID_W-1:0] nid_q;
	logic [SYMBOLS-1:0] hv_q;

	logic [SW-1:0] sym_q;
	logic rng_q;

	// histogram memory
	logic [COUNT_BITS-1:0] hist_mem [SYMBOLS];
	logic [COUNT_BITS-1:0] hist_rd_q;
	logic hv_s1;
	logic [SW-1:0] hist_addr;
	logic hist_we;
	logic [COUNT_BITS-1:0] hist_val;

	// node store
	logic [KW-1:0] heap_mem [SYMBOLS];
	logic [KW-1:0] heap_rd_q;
	logic [SW-1:0] heap_raddr, heap_waddr;
	logic heap_we;
	logic [KW-1:0] heap_wdata;

	logic rd_v_s1;
	logic [SW-1:0] rd_idx_s1;

	min2_ctl_t m2_ctl;
	logic [KW-1:0] m1_key, m2_key;
	logic [SW-1:0] m1_idx, m2_idx;

	logic [2:0] r_status_q;
	logic [ID_W-1:0] r_left_q, r_right_q, r_new_q;
	logic [COUNT_BITS-1:0] r_freq_q;
	logic r_done_q;

	logic [COUNT_BITS:0] sum_w;
	logic [COUNT_BITS-1:0] sum_sat;
	logic [KW-1:0] new_key;
	logic [SW-1:0] last_idx;
	logic [63:0] freq_x;
	logic [31:0] freq_out;
	logic accept;
	logic out_free;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	assign hist_val = hv_s1 ? hist_rd_q : '0;
	assign sum_w    = {1'b0, m1_key[KW-1:ID_W]} + {1'b0, m2_key[KW-1:ID_W]};
	assign sum_sat  = sum_w[COUNT_BITS] ? CMAX : sum_w[COUNT_BITS-1:0];
	assign new_key  = {sum_sat, nid_q};
	assign last_idx = SW'(cnt_q - CW'(1));

	// histogram address: symbol while idle, scan index while loading
	always_comb begin
		hist_addr = (state_q == S_LOAD) ? k_q[SW-1:0] : s_tdata[SW-1:0];
		hist_we   = (state_q == S_HWR) && rng_q && (hist_val != CMAX);
	end

	// histogram read and write
	always_ff @(posedge clk) begin
		hist_rd_q <= hist_mem[hist_addr];
		hv_s1     <= hv_q[hist_addr];
		if (hist_we) begin
			hist_mem[sym_q] <= hist_val + COUNT_BITS'(1);
		end
	end

	// node store read address per state
	always_comb begin
		unique case (state_q)
			S_SCAN:  heap_raddr = k_q[SW-1:0];
			S_FIX:   heap_raddr = last_idx;
			default: heap_raddr = '0;
		endcase
	end

	// node store write port
	always_comb begin
		heap_we    = 1'b0;
		heap_waddr = '0;
		heap_wdata = new_key;
		unique case (state_q)
			S_LOAD: begin
				heap_we    = rd_v_s1 && (hist_val != '0);
				heap_waddr = cnt_q[SW-1:0];
				heap_wdata = {hist_val, ID_W'(rd_idx_s1)};
			end
			S_FIX: begin
				if (m2_idx == last_idx) begin
					heap_we    = 1'b1;
					heap_waddr = m1_idx;
				end else if (m1_idx == last_idx) begin
					heap_we    = 1'b1;
					heap_waddr = m2_idx;
				end
			end
			S_MOV: begin
				heap_we    = 1'b1;
				heap_waddr = m2_idx;
				heap_wdata = heap_rd_q;
			end
			S_PUT: begin
				heap_we    = 1'b1;
				heap_waddr = m1_idx;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		heap_rd_q <= heap_mem[heap_raddr];
		if (heap_we) begin
			heap_mem[heap_waddr] <= heap_wdata;
		end
	end

	// two-minimum tracker fed by the scan
	assign m2_ctl.init = (state_q == S_MBEG);
	assign m2_ctl.take = (state_q == S_SCAN) && rd_v_s1;

	hfb_min2 #(
		.KW(KW),
		.SW(SW)
	) u_min2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (m2_ctl),
		.key      (heap_rd_q),
		.idx      (rd_idx_s1),
		.min1_key (m1_key),
		.min1_idx (m1_idx),
		.min2_key (m2_key),
		.min2_idx (m2_idx)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_COUNT;
			cnt_q   <= '0;
			k_q     <= '0;
			nid_q   <= FIRST_INTERNAL;
			hv_q    <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			// mark a read issued this cycle
			rd_v_s1 <= ((state_q == S_LOAD) && (k_q != CW'(SYMBOLS))) ||
			           ((state_q == S_SCAN) && (k_q != cnt_q));
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (s_tuser)
							REQ_COUNT: begin
								state_q <= (phase_q == PH_COUNT) ? S_HWR : S_OUT;
							end
							REQ_MERGE: begin
								k_q <= '0;
								if (phase_q == PH_DONE) begin
									state_q <= S_OUT;
								end else if (phase_q == PH_COUNT) begin
									cnt_q   <= '0;
									state_q <= S_LOAD;
								end else begin
									state_q <= S_MBEG;
								end
							end
							REQ_CLEAR: begin
								phase_q <= PH_COUNT;
								cnt_q   <= '0;
								nid_q   <= FIRST_INTERNAL;
								hv_q    <= '0;
							end
							default: ;
						endcase
					end
				end
				S_HWR: begin
					if (hist_we) begin
						hv_q[sym_q] <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_LOAD: begin
					if (k_q != CW'(SYMBOLS)) begin
						k_q <= k_q + CW'(1);
					end
					if (heap_we) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (k_q == CW'(SYMBOLS) && !rd_v_s1) begin
						if (cnt_q == '0) begin
							state_q <= S_OUT;
						end else begin
							phase_q <= PH_MERGE;
							state_q <= S_MBEG;
						end
					end
				end
				S_MBEG: begin
					k_q     <= '0;
					state_q <= (cnt_q == CW'(1)) ? S_SGL : S_SCAN;
				end
				S_SGL: begin
					phase_q <= PH_DONE;
					state_q <= S_OUT;
				end
				S_SCAN: begin
					if (k_q != cnt_q) begin
						k_q <= k_q + CW'(1);
					end else if (!rd_v_s1) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					if (heap_we) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_MOV;
					end
				end
				S_MOV: begin
					state_q <= S_PUT;
				end
				S_PUT: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// finish a merge: shrink the store and number the new node
			if ((state_q == S_FIX && heap_we) || state_q == S_PUT) begin
				cnt_q <= cnt_q - CW'(1);
				nid_q <= nid_q + ID_W'(1);
				if (cnt_q == CW'(2)) begin
					phase_q <= PH_DONE;
				end
			end
		end
	end

	// register the read index in step with the read data
	always_ff @(posedge clk) begin
		rd_idx_s1 <= k_q[SW-1:0];
		if (accept) begin
			sym_q <= s_tdata[SW-1:0];
			rng_q <= ({1'b0, s_tdata} < 9'(SYMBOLS));
		end
	end

	// build the pending result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				r_status_q <= ST_DONE;
				r_left_q   <= '0;
				r_right_q  <= '0;
				r_new_q    <= '0;
				r_freq_q   <= '0;
				r_done_q   <= 1'b0;
			end
			S_HWR: r_status_q <= ST_COUNTED;
			S_LOAD: r_status_q <= ST_EMPTY;
			S_SGL: begin
				r_status_q <= ST_SINGLE;
				r_new_q    <= heap_rd_q[ID_W-1:0];
				r_freq_q   <= heap_rd_q[KW-1:ID_W];
				r_done_q   <= 1'b1;
			end
			S_FIX: begin
				r_status_q <= ST_MERGED;
				r_left_q   <= m1_key[ID_W-1:0];
				r_right_q  <= m2_key[ID_W-1:0];
				r_new_q    <= nid_q;
				r_freq_q   <= sum_sat;
				r_done_q   <= (cnt_q == CW'(2));
			end
			default: ;
		endcase
	end

	assign freq_x   = 64'(r_freq_q);
	assign freq_out = (|freq_x[63:32]) ? 32'hFFFF_FFFF : freq_x[31:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			m_tdata <= {5'b00000, freq_out, r_new_q, r_right_q, r_left_q};
			m_tuser <= r_status_q;
			m_tlast <= r_done_q;
		end
	end

endmodule

### bench/tb.sv
// Self-checking bench of the Huffman tree builder: predictor, stimulus and result checker.
module tb import hfb_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SYMBOLS    = 256;
	localparam int COUNT_BITS = 32;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [2:0]  status;
		logic [8:0]  left_node;
		logic [8:0]  right_node;
		logic [8:0]  new_node;
		logic [31:0] merged_freq;
		logic        tree_done;
	} merge_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] symbol
	logic [1:0]  s_tuser;   // [1:0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // [8:0] left, [17:9] right, [26:18] new, [58:27] freq
	logic [2:0]  m_tuser;   // [2:0] status
	logic        m_tlast;   // tree_done

	huffman_tree_builder_top #(.SYMBOLS(SYMBOLS), .COUNT_BITS(COUNT_BITS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// predictor state
	logic [COUNT_BITS-1:0] hist_cnt [SYMBOLS];
	logic [COUNT_BITS-1:0] node_freq [SYMBOLS];
	logic [8:0]            node_id [SYMBOLS];
	int                    node_cnt;
	logic [8:0]            next_id;
	logic [1:0]            phase;

	merge_result_t expected_results [$];
	int  mismatch_cnt;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  recv_hold;

	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	task automatic tree_reset();
		for (int i = 0; i < SYMBOLS; i++) hist_cnt[i] = '0;
		node_cnt = 0;
		next_id  = FIRST_INTERNAL;
		phase    = PH_COUNT;
	endtask

	// remove the least (frequency, id) node
	task automatic take_least(output logic [8:0] id, output logic [COUNT_BITS-1:0] f);
		int best;
		best = 0;
		for (int k = 1; k < node_cnt; k++)
			if (node_freq[k] < node_freq[best] ||
			    (node_freq[k] == node_freq[best] && node_id[k] < node_id[best]))
				best = k;
		id = node_id[best];
		f  = node_freq[best];
		node_cnt--;
		node_id[best]   = node_id[node_cnt];
		node_freq[best] = node_freq[node_cnt];
	endtask

	task automatic predict_request(input logic [1:0] req, input logic [7:0] sym);
		merge_result_t r;
		logic [8:0] la, rb;
		logic [COUNT_BITS-1:0] lf, rf;
		logic [COUNT_BITS:0] sum;
		r = '0;
		if (req == REQ_CLEAR) begin
			tree_reset();
			return;
		end
		if (req == REQ_UNUSED) return;
		if (req == REQ_COUNT) begin
			if (phase != PH_COUNT) r.status = ST_DONE;
			else begin
				if (sym < SYMBOLS && hist_cnt[sym] != COUNT_MAX) hist_cnt[sym]++;
				r.status = ST_COUNTED;
			end
			expected_results.push_back(r);
			return;
		end
		if (phase == PH_DONE) begin
			r.status = ST_DONE;
			expected_results.push_back(r);
			return;
		end
		if (phase == PH_COUNT) begin
			node_cnt = 0;
			for (int s = 0; s < SYMBOLS; s++)
				if (hist_cnt[s] != 0) begin
					node_id[node_cnt]   = s[8:0];
					node_freq[node_cnt] = hist_cnt[s];
					node_cnt++;
				end
			if (node_cnt == 0) begin
				r.status = ST_EMPTY;
				expected_results.push_back(r);
				return;
			end
			phase = PH_MERGE;
		end
		if (node_cnt == 1) begin
			r.status      = ST_SINGLE;
			r.new_node    = node_id[0];
			r.merged_freq = node_freq[0];
			r.tree_done   = 1'b1;
			phase = PH_DONE;
			expected_results.push_back(r);
			return;
		end
		take_least(la, lf);
		take_least(rb, rf);
		sum = {1'b0, lf} + {1'b0, rf};
		if (sum > {1'b0, COUNT_MAX}) sum = {1'b0, COUNT_MAX};
		node_id[node_cnt]   = next_id;
		node_freq[node_cnt] = sum[COUNT_BITS-1:0];
		node_cnt++;
		r.status      = ST_MERGED;
		r.left_node   = la;
		r.right_node  = rb;
		r.new_node    = next_id;
		r.merged_freq = sum[31:0];
		next_id = next_id + 9'd1;
		if (node_cnt == 1) begin
			r.tree_done = 1'b1;
			phase = PH_DONE;
		end
		expected_results.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
		mismatch_cnt++;
		$display("MISMATCH %s: got %0h want %0h", what, got, want);
	endtask

	// send one transaction after a random idle gap
	task automatic send_request(input logic [1:0] req, input logic [7:0] sym);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= sym;
		predict_request(req, sym);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// receiver ready with random stalls and an optional long hold
	always @(posedge clk) begin
		if (recv_hold) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		merge_result_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0)
				report_mismatch("unexpected result", m_tdata, 64'd0);
			else begin
				w = expected_results.pop_front();
				if (m_tuser != w.status)
					report_mismatch("status", 64'(m_tuser), 64'(w.status));
				if (m_tdata[8:0] != w.left_node)
					report_mismatch("left_node", 64'(m_tdata[8:0]), 64'(w.left_node));
				if (m_tdata[17:9] != w.right_node)
					report_mismatch("right_node", 64'(m_tdata[17:9]), 64'(w.right_node));
				if (m_tdata[26:18] != w.new_node)
					report_mismatch("new_node", 64'(m_tdata[26:18]), 64'(w.new_node));
				if (m_tdata[58:27] != w.merged_freq)
					report_mismatch("merged_freq", 64'(m_tdata[58:27]), 64'(w.merged_freq));
				if (m_tlast != w.tree_done)
					report_mismatch("tree_done", 64'(m_tlast), 64'(w.tree_done));
			end
		end
	end

	// clear, count n_counts symbols, then issue up to n_counts + 2 merges (some counts)
	task automatic run_tree(input int n_counts, input int sym_span, output int n_sent);
		int merges;
		n_sent = 0;
		send_request(REQ_CLEAR, 8'($urandom));
		n_sent++;
		for (int i = 0; i < n_counts; i++) begin
			send_request(REQ_COUNT, 8'($urandom_range(sym_span)));
			n_sent++;
		end
		merges = $urandom_range(n_counts + 2);
		for (int i = 0; i < merges; i++) begin
			send_request($urandom_range(9) == 0 ? REQ_COUNT : REQ_MERGE, 8'($urandom));
			n_sent++;
		end
	endtask

	task automatic test_directed();
		send_request(REQ_MERGE, 8'd0);      // no symbols
		send_request(REQ_UNUSED, 8'hA5);    // ignored code
		send_request(REQ_COUNT, 8'hFF);
		send_request(REQ_MERGE, 8'd0);      // single leaf
		send_request(REQ_MERGE, 8'd0);      // after completion
		send_request(REQ_COUNT, 8'd1);      // count after completion
		send_request(REQ_CLEAR, 8'd0);
		send_request(REQ_COUNT, 8'h00);
		send_request(REQ_COUNT, 8'hFF);
		send_request(REQ_COUNT, 8'h80);
		send_request(REQ_COUNT, 8'h80);
		send_request(REQ_COUNT, 8'h7F);
		send_request(REQ_MERGE, 8'd0);
		send_request(REQ_COUNT, 8'h10);     // count while building
		send_request(REQ_MERGE, 8'd0);
		send_request(REQ_MERGE, 8'd0);
		send_request(REQ_MERGE, 8'd0);
		send_request(REQ_MERGE, 8'd0);
		send_request(REQ_CLEAR, 8'd0);
	endtask

	task automatic test_random(input int n_items);
		int sent;
		int n;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				send_request(2'($urandom_range(3)), 8'($urandom));
				sent++;
			end else begin
				run_tree($urandom_range(3, 14), $urandom_range(1) ? 255 : 7, n);
				sent += n;
			end
		end
	endtask

	// send count requests while the receiver holds off, stalling the sequencer
	task automatic test_backpressure();
		recv_hold <= 1'b1;
		fork
			begin repeat (400) @(posedge clk); recv_hold <= 1'b0; end
			for (int i = 0; i < 8; i++) send_request(REQ_COUNT, 8'($urandom));
		join
		wait_drained();
		send_request(REQ_MERGE, 8'd0);
	endtask

	initial begin
		arst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
		recv_hold = 1'b0; mismatch_cnt = 0; send_idle_pct = 19; recv_idle_pct = 63;
		tree_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(550);
		wait_drained();
		send_idle_pct = 63; recv_idle_pct = 19;
		test_backpressure();
		test_random(550);
		wait_drained();
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(550);
		wait_drained();
		if (mismatch_cnt == 0 && expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
